/* rtl/spq_pkg.sv */
// spq_pkg: shared types, codes and default sizes for the sorted priority queue
// used by spq_cell, sorted_priority_queue and spq_checker
// no dependencies

package spq_pkg;

    // default sizes, handed down through the top level's parameters
    localparam int SPQ_DEPTH     = 16;
    localparam int SPQ_PRIO_BITS = 16;
    localparam int SPQ_ITEM_BITS = 16;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

    // request beat
    typedef struct packed {
        logic        op;
        logic [15:0] prio_in;
        logic [15:0] item_in;
    } spq_req_t;

    // response beat
    typedef struct packed {
        logic        head_valid;
        logic [15:0] head_item;
        logic [4:0]  entry_count;
        logic [1:0]  status;
    } spq_rsp_t;

    // per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic push;
        logic pop;
    } spq_cmd_t;

endpackage

/* rtl/spq_cell.sv */
// spq_cell: one slot of the sorted row, holding a priority and an item
// depends on spq_pkg (spq_cmd_t, default sizes)

module spq_cell
    import spq_pkg::*;
#(
    parameter int PRIO_BITS = SPQ_PRIO_BITS,
    parameter int ITEM_BITS = SPQ_ITEM_BITS
)
(
    input  logic                 clk,
    input  spq_cmd_t             cmd,
    input  logic                 occupied,
    input  logic [PRIO_BITS-1:0] new_prio,
    input  logic [ITEM_BITS-1:0] new_item,
    input  logic                 left_stay,
    input  logic [PRIO_BITS-1:0] left_prio,
    input  logic [ITEM_BITS-1:0] left_item,
    input  logic [PRIO_BITS-1:0] right_prio,
    input  logic [ITEM_BITS-1:0] right_item,
    output logic                 stay,
    output logic [PRIO_BITS-1:0] prio,
    output logic [ITEM_BITS-1:0] item
);

    logic [PRIO_BITS-1:0] prio_reg;
    logic [PRIO_BITS-1:0] prio_next;
    logic [ITEM_BITS-1:0] item_reg;
    logic [ITEM_BITS-1:0] item_next;

    // a stored entry of lower or equal priority keeps its place on a push
    assign stay = occupied && (prio_reg <= new_prio);

    // slot update: hold, insert the new entry, shift right on push, shift left on pop
    always_comb
    begin
        prio_next = prio_reg;
        item_next = item_reg;
        if (cmd.push)
        begin
            if (!stay)
            begin
                if (left_stay)
                begin
                    prio_next = new_prio;
                    item_next = new_item;
                end
                else
                begin
                    prio_next = left_prio;
                    item_next = left_item;
                end
            end
        end
        else if (cmd.pop)
        begin
            prio_next = right_prio;
            item_next = right_item;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        item_reg <= item_next;
    end

    assign prio = prio_reg;
    assign item = item_reg;

endmodule

/* rtl/sorted_priority_queue.sv */
// Sorted priority queue of DEPTH entries built as a row of compare-and-shift
// cells, slot 0 holding the head. A smaller priority leaves first and equal
// priorities leave in arrival order. Every cell compares its entry with the
// pushed priority in the same cycle and either holds, takes the new entry or
// takes its neighbour's. The block takes one request beat per cycle while
// req_stall is low, and it returns its response beat in the
// cycle after acceptance. While a response waits under stall, the request
// side stalls too. The stored entries need no clearing after reset; the fill
// count alone marks which slots hold data. entry_count carries the low five
// bits of the fill count.
// depends on spq_pkg and spq_cell

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH     = SPQ_DEPTH,
    parameter int PRIO_BITS = SPQ_PRIO_BITS,
    parameter int ITEM_BITS = SPQ_ITEM_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  spq_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output spq_rsp_t rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;

    logic                 accept;
    logic                 full;
    logic                 empty;
    spq_cmd_t             cmd;
    logic [PRIO_BITS-1:0] new_prio;
    logic [ITEM_BITS-1:0] new_item;

    logic [PRIO_BITS-1:0] cell_prio [DEPTH];
    logic [ITEM_BITS-1:0] cell_item [DEPTH];
    logic                 cell_stay [DEPTH];

    // handshake: a waiting response holds the request side
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign new_prio = PRIO_BITS'(req.prio_in);
    assign new_item = ITEM_BITS'(req.item_in);

    // command to the row, suppressed on full push and empty pop
    always_comb
    begin
        cmd.push = accept && (req.op == OP_PUSH) && !full;
        cmd.pop  = accept && (req.op == OP_POP) && !empty;
    end

    // row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                 left_stay;
        logic [PRIO_BITS-1:0] left_prio;
        logic [ITEM_BITS-1:0] left_item;
        logic [PRIO_BITS-1:0] right_prio;
        logic [ITEM_BITS-1:0] right_item;

        if (i == 0)
        begin : g_first
            assign left_stay = 1'b1;
            assign left_prio = new_prio;
            assign left_item = new_item;
        end
        else
        begin : g_inner
            assign left_stay = cell_stay[i-1];
            assign left_prio = cell_prio[i-1];
            assign left_item = cell_item[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_prio = cell_prio[i];
            assign right_item = cell_item[i];
        end
        else
        begin : g_body
            assign right_prio = cell_prio[i+1];
            assign right_item = cell_item[i+1];
        end

        spq_cell #(
            .PRIO_BITS (PRIO_BITS),
            .ITEM_BITS (ITEM_BITS)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .occupied   (CNT_W'(i) < count_reg),
            .new_prio   (new_prio),
            .new_item   (new_item),
            .left_stay  (left_stay),
            .left_prio  (left_prio),
            .left_item  (left_item),
            .right_prio (right_prio),
            .right_item (right_item),
            .stay       (cell_stay[i]),
            .prio       (cell_prio[i]),
            .item       (cell_item[i])
        );
    end

    // fill count, status and response valid
    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        if (cmd.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - 1'b1;
        end

        if (accept)
        begin
            if ((req.op == OP_PUSH) && full)
            begin
                status_next = ST_PUSH_FULL;
            end
            else if ((req.op == OP_POP) && empty)
            begin
                status_next = ST_POP_EMPTY;
            end
            else
            begin
                status_next = ST_OK;
            end
        end

        rsp_valid_next = accept || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            status_reg    <= status_next;
        end
    end

    // response beat, read from the head cell and the count
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        rsp.head_valid  = !empty;
        rsp.head_item   = empty ? 16'd0 : 16'(cell_item[0]);
        rsp.entry_count = 5'(count_reg);
        rsp.status      = status_reg;
    end

endmodule

/* rtl/spq_checker.sv */
// spq_checker: port-level assertions for sorted_priority_queue, and its bind
// depends on spq_pkg and sorted_priority_queue

module spq_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
)
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_stall,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input spq_rsp_t rsp
);

    // an accepted request beat always yields a response beat next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> rsp_valid)
        else $error("accepted request gave no response beat");

    // a stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response beat changed");

    // head flag agrees with the entry count
    a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.head_valid == (rsp.entry_count != 5'd0)))
        else $error("head flag disagrees with entry count");

    // pop on empty leaves the queue empty
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == ST_POP_EMPTY))
            |-> (!rsp.head_valid && (rsp.entry_count == 5'd0)))
        else $error("empty pop reported a nonempty queue");

    // a dropped push only happens at full occupancy
    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == ST_PUSH_FULL))
            |-> (rsp.entry_count == 5'(DEPTH)))
        else $error("push dropped below full occupancy");

endmodule

bind sorted_priority_queue spq_checker #(
    .DEPTH (DEPTH)
) u_spq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for sorted_priority_queue, with a shadow queue that predicts
// every response beat and random idling on both channels
// depends on spq_pkg and the sorted_priority_queue rtl

module tb_top;
    import spq_pkg::*;

    // shadow copy of the sorted store, with the response beats still due from the block
    class queue_shadow;
        logic [SPQ_PRIO_BITS-1:0] slot_prio [SPQ_DEPTH];
        logic [SPQ_ITEM_BITS-1:0] slot_item [SPQ_DEPTH];
        int unsigned              fill;
        spq_rsp_t                 rsp_due [$];
        int unsigned              errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // one line per mismatch, and count it
        task flag_field(string what);
            errors++;
            $display("%0t ns mismatch: %s", $time, what);
        endtask

        // apply one accepted request beat and queue the response it must produce
        function void apply_request(spq_req_t beat);
            spq_rsp_t    due;
            int unsigned pos;
            int unsigned k;
            due.status = ST_OK;
            if (beat.op == OP_PUSH)
            begin
                if (fill >= SPQ_DEPTH)
                    due.status = ST_PUSH_FULL;
                else
                begin
                    // newcomer goes behind every entry of lower or equal priority
                    pos = 0;
                    while (pos < fill && slot_prio[pos] <= beat.prio_in)
                        pos++;
                    for (k = fill; k > pos; k--)
                    begin
                        slot_prio[k] = slot_prio[k-1];
                        slot_item[k] = slot_item[k-1];
                    end
                    slot_prio[pos] = beat.prio_in;
                    slot_item[pos] = beat.item_in;
                    fill++;
                end
            end
            else if (fill == 0)
                due.status = ST_POP_EMPTY;
            else
            begin
                for (k = 1; k < fill; k++)
                begin
                    slot_prio[k-1] = slot_prio[k];
                    slot_item[k-1] = slot_item[k];
                end
                fill--;
            end
            due.head_valid  = (fill != 0);
            due.head_item   = (fill != 0) ? slot_item[0] : '0;
            due.entry_count = fill[4:0];
            rsp_due.push_back(due);
        endfunction

        // compare one accepted response beat against the oldest one due
        task check_response(spq_rsp_t got);
            spq_rsp_t due;
            if (rsp_due.size() == 0)
            begin
                flag_field($sformatf("response beat with nothing due: %p", got));
                return;
            end
            due = rsp_due.pop_front();
            if (got.head_valid !== due.head_valid)
                flag_field($sformatf("head_valid %0b, want %0b", got.head_valid, due.head_valid));
            if (got.head_item !== due.head_item)
                flag_field($sformatf("head_item %h, want %h", got.head_item, due.head_item));
            if (got.entry_count !== due.entry_count)
                flag_field($sformatf("entry_count %0d, want %0d",
                                     got.entry_count, due.entry_count));
            if (got.status !== due.status)
                flag_field($sformatf("status %0d, want %0d", got.status, due.status));
        endtask
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    spq_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    spq_rsp_t rsp;

    queue_shadow shadow;
    bit          gaps_on;
    bit          stall_on;
    int          stall_left = 0;
    int          beats_sent;

    sorted_priority_queue dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // 10 ns clock
    always #5 clk = ~clk;

    // response side stall: mostly short bursts, now and then a long one
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!stall_on || $urandom_range(0, 99) < 70)
            rsp_stall <= 1'b0;
        else
        begin
            rsp_stall  <= 1'b1;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25)
                                                       : $urandom_range(0, 2);
        end
    end

    // check every response beat the block hands over
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            shadow.check_response(rsp);
    end

    // gap length before the next request beat
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // present one beat and hold it until the block takes it
    task automatic send_beat(spq_req_t beat);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        do
            @(posedge clk);
        while (req_stall);
        shadow.apply_request(beat);
        beats_sent++;
    endtask

    task automatic send_op(logic op, logic [15:0] prio, logic [15:0] item);
        spq_req_t beat;
        beat.op      = op;
        beat.prio_in = prio;
        beat.item_in = item;
        send_beat(beat);
    endtask

    // hold off requests until every response due has come back
    task automatic drain();
        req_valid <= 1'b0;
        while (shadow.rsp_due.size() != 0)
            @(posedge clk);
    endtask

    // random beat; ties are common thanks to the narrow priority band
    function automatic spq_req_t random_beat(int push_pct);
        spq_req_t beat;
        int       pick;
        beat.op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        pick = $urandom_range(0, 3);
        if (pick < 2)
            beat.prio_in = 16'($urandom_range(0, 7));
        else if (pick == 2)
            beat.prio_in = 16'($urandom_range(0, 16'hFFFF));
        else
            beat.prio_in = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        if ($urandom_range(0, 9) == 0)
            beat.item_in = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        else
            beat.item_in = 16'($urandom_range(0, 16'hFFFF));
        return beat;
    endfunction

    // limit on the whole run
    initial
    begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // main sequence
    initial
    begin
        logic [15:0] band [3];
        int          epoch_len;
        int          push_pct;
        int          epoch;
        int          i;
        shadow     = new();
        beats_sent = 0;
        gaps_on    = 1'b0;
        stall_on   = 1'b0;
        band[0]    = 16'h0000;
        band[1]    = 16'h8000;
        band[2]    = 16'hFFFF;
        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        req        <= '0;
        rsp_stall  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: pop on empty, fill with extreme and tied priorities, push on full, then four pops
        send_op(OP_POP, 16'h1234, 16'h5678);
        send_op(OP_PUSH, 16'hFFFF, 16'h0000);
        send_op(OP_PUSH, 16'h0000, 16'hFFFF);
        for (i = 2; i < SPQ_DEPTH; i++)
            send_op(OP_PUSH, band[i % 3], 16'(i * 16'h1111));
        send_op(OP_PUSH, 16'h0000, 16'hBEEF);
        for (i = 0; i < 4; i++)
            send_op(OP_POP, 16'hFFFF, 16'hFFFF);
        drain();

        // random: epochs that lean towards filling, draining or neither
        epoch = 0;
        while (beats_sent < 1025)
        begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stall_on  = ($urandom_range(0, 3) != 0);
            epoch_len = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
                0:       push_pct = 80;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            for (i = 0; i < epoch_len; i++)
                send_beat(random_beat(push_pct));
            epoch++;
            if (epoch % 5 == 0)
                drain();
        end

        // wind down
        drain();
        repeat (10) @(posedge clk);
        if (shadow.errors == 0 && shadow.rsp_due.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
bench/tb_top.sv
